### hdl/smp_pkg.sv
// ---------------------------------------------------------------------------
// smp_pkg
// Shared types and constants of the service message parser.
// ---------------------------------------------------------------------------
package smp_pkg;

	// field tags, in format order
	localparam logic [4:0] TAG_SID    = 5'd0;
	localparam logic [4:0] TAG_VLEN   = 5'd1;
	localparam logic [4:0] TAG_VID    = 5'd2;
	localparam logic [4:0] TAG_CLASS  = 5'd3;
	localparam logic [4:0] TAG_STAT   = 5'd4;
	localparam logic [4:0] TAG_FLAGS  = 5'd5;
	localparam logic [4:0] TAG_HOR    = 5'd6;
	localparam logic [4:0] TAG_CONF   = 5'd7;
	localparam logic [4:0] TAG_EXP    = 5'd8;
	localparam logic [4:0] TAG_FALL   = 5'd9;
	localparam logic [4:0] TAG_WCNT   = 5'd10;
	localparam logic [4:0] TAG_WLAT   = 5'd11;
	localparam logic [4:0] TAG_WLON   = 5'd12;
	localparam logic [4:0] TAG_WEL    = 5'd13;
	localparam logic [4:0] TAG_WSP    = 5'd14;
	localparam logic [4:0] TAG_WDW    = 5'd15;
	localparam logic [4:0] TAG_OCNT   = 5'd16;
	localparam logic [4:0] TAG_OID    = 5'd17;
	localparam logic [4:0] TAG_OCLS   = 5'd18;
	localparam logic [4:0] TAG_OLAT   = 5'd19;
	localparam logic [4:0] TAG_OLON   = 5'd20;
	localparam logic [4:0] TAG_OEL    = 5'd21;
	localparam logic [4:0] TAG_OVL    = 5'd22;
	localparam logic [4:0] TAG_COVL   = 5'd23;
	localparam logic [4:0] TAG_COV    = 5'd24;
	localparam logic [4:0] TAG_CCNT   = 5'd25;
	localparam logic [4:0] TAG_AXIS   = 5'd26;
	localparam logic [4:0] TAG_CVAL   = 5'd27;
	localparam logic [4:0] TAG_PAY    = 5'd28;
	localparam logic [4:0] TAG_TASK   = 5'd29;

	// status codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SHORT     = 4'd1;
	localparam logic [3:0] ST_TRUNC     = 4'd2;
	localparam logic [3:0] ST_SEC_TRUNC = 4'd3;
	localparam logic [3:0] ST_LIM_BASE  = 4'd4;

	// limit fault bits (code minus base)
	localparam int LB_VEH   = 0;
	localparam int LB_HOR   = 1;
	localparam int LB_CONF  = 2;
	localparam int LB_WPT   = 3;
	localparam int LB_SPD   = 4;
	localparam int LB_DWELL = 5;
	localparam int LB_OBJ   = 6;
	localparam int LB_CMD   = 7;
	localparam int LB_VAL   = 8;
	localparam int LIM_BITS = 9;

	// limits
	localparam logic [7:0]  MAX_VID_LEN   = 8'd16;
	localparam logic [63:0] MAX_HORIZON   = 64'd60000;
	localparam logic [63:0] MAX_CONF      = 64'd100;
	localparam logic [63:0] MAX_WAYPOINTS = 64'd50;
	localparam logic [63:0] MAX_OBJECTS   = 64'd64;
	localparam logic [63:0] MAX_DWELL     = 64'd10000;
	localparam logic [63:0] MAX_COMMANDS  = 64'd10;
	localparam logic [63:0] CMD_OFFSET    = 64'd32768;
	localparam logic [63:0] CMD_SPAN      = 64'd1000;
	localparam logic [63:0] DBL_INF_MAG   = 64'h7FF0_0000_0000_0000;

	typedef struct packed {
		logic        kind;
		logic [4:0]  tag;
		logic [63:0] value;
		logic [15:0] elem;
		logic [15:0] bytn;
		logic [3:0]  status;
		logic        run_end;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

### hdl/smp_if.sv
// ---------------------------------------------------------------------------
// smp_in_if / smp_out_if
// Valid/ready channels for message bytes and parse results.
// ---------------------------------------------------------------------------
interface smp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source(output valid, output data_byte, output final_byte, input ready);
	modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface smp_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [4:0]  field_tag;
	logic [63:0] field_value;
	logic [15:0] element_number;
	logic [15:0] byte_number;
	logic [3:0]  status_code;
	logic        run_end;

	modport source(output valid, output result_kind, output field_tag, output field_value,
		output element_number, output byte_number, output status_code, output run_end,
		input ready);
	modport sink(input valid, input result_kind, input field_tag, input field_value,
		input element_number, input byte_number, input status_code, input run_end,
		output ready);
endinterface

### hdl/service_message_parser_unit.sv
// ---------------------------------------------------------------------------
// service_message_parser_unit
// Byte-serial parser for cooperative-service messages.
// ---------------------------------------------------------------------------
// in_ch carries one message byte per request, final_byte marks the last one.
// out_ch carries results: decoded fields as their last byte arrives, and a
// status result after the final byte (fields are tentative until then).
// Throughput: one byte per cycle while in_ch.ready is high; the parse step
// is one pass of logic from the state registers into a four-entry result
// queue, which drives out_ch. A final byte that also completes a field makes
// two results, drained one per cycle while out_ch.ready is high.
// in_ch.ready is low while fewer than two queue slots are free, so a stalled
// receiver backs up into the byte stream once three or more results wait.
// Reset clears the parse state and the queue; the parser also returns to the
// reset state after each status result.
// ---------------------------------------------------------------------------
module service_message_parser_unit #(
	parameter int SESSION_ID_BYTES = 16,
	parameter int OBJECT_ID_BYTES  = 16
) (
	input logic      clk,
	input logic      arst_n,
	smp_in_if.sink   in_ch,
	smp_out_if.source out_ch
);

	logic             room, avail, accept;
	smp_pkg::push_t   push;
	smp_pkg::result_t head;

	assign in_ch.ready = room;
	assign accept      = in_ch.valid && room;

	smp_parser #(
		.SESSION_ID_BYTES(SESSION_ID_BYTES),
		.OBJECT_ID_BYTES(OBJECT_ID_BYTES)
	) u_parser (
		.clk(clk), .arst_n(arst_n), .accept(accept),
		.data_byte(in_ch.data_byte), .final_byte(in_ch.final_byte), .push(push)
	);

	smp_result_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .pop(out_ch.ready),
		.room(room), .avail(avail), .head(head)
	);

	assign out_ch.valid          = avail;
	assign out_ch.result_kind    = head.kind;
	assign out_ch.field_tag      = head.tag;
	assign out_ch.field_value    = head.value;
	assign out_ch.element_number = head.elem;
	assign out_ch.byte_number    = head.bytn;
	assign out_ch.status_code    = head.status;
	assign out_ch.run_end        = head.run_end;

endmodule

### hdl/smp_parser.sv
// ---------------------------------------------------------------------------
// smp_parser
// Parse state and the one-byte step; yields up to two results per byte.
// ---------------------------------------------------------------------------
module smp_parser #(
	parameter int SESSION_ID_BYTES = 16,
	parameter int OBJECT_ID_BYTES  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            final_byte,
	output smp_pkg::push_t  push
);

	typedef enum logic [5:0] {
		PH_SID, PH_VLEN, PH_VID, PH_CLASS, PH_STAT, PH_FLAGS, PH_HOR, PH_CONF, PH_EXP,
		PH_PLEN, PH_OLEN, PH_CLEN, PH_BLEN, PH_TLEN, PH_FALL, PH_WCNT, PH_WLAT, PH_WLON,
		PH_WELF, PH_WEL, PH_WSPF, PH_WSP, PH_WDWF, PH_WDW, PH_OCNT, PH_OID, PH_OCLS,
		PH_OLAT, PH_OLON, PH_OELF, PH_OEL, PH_OVLF, PH_OVL, PH_COVL, PH_COV, PH_CCNT,
		PH_AXIS, PH_CVAL, PH_PAY, PH_TASK, PH_SKIP, PH_SKIPF, PH_DONE, PH_STOP
	} phase_t;

	typedef enum logic [3:0] {
		A_NONE, A_NEED, A_FAULT, A_NEXT_HDR, A_END_SEC, A_NEXT_SEC,
		A_FIN_WP, A_NEXT_WP, A_FIN_OBJ, A_NEXT_OBJ, A_FIN_CMD, A_NEXT_CMD
	} act_t;

	localparam logic [7:0]  SID_LEN   = 8'(SESSION_ID_BYTES);
	localparam logic [7:0]  SHORT_LEN = 8'(SESSION_ID_BYTES + 4);
	localparam logic [15:0] OID_LEN   = 16'(OBJECT_ID_BYTES);

	phase_t                      phase_q;
	logic [7:0]                  pflags_q, hcount_q;
	logic [15:0]                 sec_left_q, elem_left_q, elem_idx_q, blob_left_q;
	logic [3:0]                  fbytes_q, fault_q;
	logic [63:0]                 vshift_q;
	logic [smp_pkg::LIM_BITS-1:0] lim_q;

	phase_t                      ph_n;
	logic [7:0]                  pf_n, hc_n;
	logic [15:0]                 sl_n, el_n, ei_n, bl_n;
	logic [3:0]                  fb_n, fc_n;
	logic [63:0]                 vs_n;
	logic [smp_pkg::LIM_BITS-1:0] lf_n;
	smp_pkg::push_t              push_c;

	always_comb begin
		act_t        act;
		phase_t      need_ph;
		logic [3:0]  need_n, width;
		logic        has;
		logic [4:0]  tag;
		logic [63:0] val, mag;
		logic [15:0] elem, bytn;
		logic [3:0]  code;
		smp_pkg::result_t fr, sr;

		ph_n = phase_q; pf_n = pflags_q; hc_n = hcount_q; sl_n = sec_left_q;
		el_n = elem_left_q; ei_n = elem_idx_q; bl_n = blob_left_q; fb_n = fbytes_q;
		vs_n = vshift_q; fc_n = fault_q; lf_n = lim_q;
		act = A_NONE; need_ph = PH_STOP; need_n = 4'd0; width = 4'd2;
		has = 1'b0; tag = '0; val = '0; elem = '0; bytn = '0; code = smp_pkg::ST_OK;
		mag = '0;

		if (hc_n != 8'hFF) hc_n = hc_n + 8'd1;
		if (phase_q >= PH_FALL && phase_q <= PH_SKIPF && sl_n != 16'd0)
			sl_n = sl_n - 16'd1;

		case (phase_q)
			PH_SID: begin
				has = 1'b1; tag = smp_pkg::TAG_SID; val = 64'(data_byte);
				bytn = 16'(hc_n - 8'd1);
				if (hc_n >= SID_LEN) ph_n = PH_VLEN;
			end
			PH_VLEN: begin
				has = 1'b1; tag = smp_pkg::TAG_VLEN; val = 64'(data_byte);
				if (data_byte == 8'd0 || data_byte > smp_pkg::MAX_VID_LEN)
					lf_n[smp_pkg::LB_VEH] = 1'b1;
				bl_n = 16'(data_byte); vs_n = '0;
				ph_n = (data_byte != 8'd0) ? PH_VID : PH_CLASS;
			end
			PH_VID: begin
				has = 1'b1; tag = smp_pkg::TAG_VID; val = 64'(data_byte);
				bytn = vs_n[15:0]; vs_n = vs_n + 64'd1;
				if (bl_n != 16'd0) bl_n = bl_n - 16'd1;
				if (bl_n == 16'd0) ph_n = PH_CLASS;
			end
			PH_CLASS: begin
				has = 1'b1; tag = smp_pkg::TAG_CLASS; val = 64'(data_byte); ph_n = PH_STAT;
			end
			PH_STAT: begin
				has = 1'b1; tag = smp_pkg::TAG_STAT; val = 64'(data_byte); ph_n = PH_FLAGS;
			end
			PH_FLAGS: begin
				has = 1'b1; tag = smp_pkg::TAG_FLAGS; val = 64'(data_byte);
				pf_n = data_byte; act = A_NEXT_HDR;
			end
			PH_FALL: begin
				has = 1'b1; tag = smp_pkg::TAG_FALL; val = 64'(data_byte != 8'd0);
				act = A_NEED; need_ph = PH_WCNT; need_n = 4'd2;
			end
			PH_WELF: begin
				act = A_NEED;
				if (data_byte != 8'd0) begin need_ph = PH_WEL; need_n = 4'd8; end
				else begin need_ph = PH_WSPF; need_n = 4'd1; end
			end
			PH_WSPF: begin
				act = A_NEED;
				if (data_byte != 8'd0) begin need_ph = PH_WSP; need_n = 4'd8; end
				else begin need_ph = PH_WDWF; need_n = 4'd1; end
			end
			PH_WDWF: begin
				if (data_byte != 8'd0) begin
					act = A_NEED; need_ph = PH_WDW; need_n = 4'd2;
				end else act = A_FIN_WP;
			end
			PH_OID: begin
				has = 1'b1; tag = smp_pkg::TAG_OID; val = 64'(data_byte); elem = ei_n;
				bytn = vs_n[15:0]; vs_n = vs_n + 64'd1;
				if (bl_n != 16'd0) bl_n = bl_n - 16'd1;
				if (bl_n == 16'd0) begin act = A_NEED; need_ph = PH_OCLS; need_n = 4'd1; end
			end
			PH_OCLS: begin
				has = 1'b1; tag = smp_pkg::TAG_OCLS; val = 64'(data_byte); elem = ei_n;
				act = A_NEED; need_ph = PH_OLAT; need_n = 4'd8;
			end
			PH_OELF: begin
				act = A_NEED;
				if (data_byte != 8'd0) begin need_ph = PH_OEL; need_n = 4'd8; end
				else begin need_ph = PH_OVLF; need_n = 4'd1; end
			end
			PH_OVLF: begin
				act = A_NEED;
				if (data_byte != 8'd0) begin need_ph = PH_OVL; need_n = 4'd8; end
				else begin need_ph = PH_COVL; need_n = 4'd1; end
			end
			PH_COVL: begin
				has = 1'b1; tag = smp_pkg::TAG_COVL; val = 64'(data_byte); elem = ei_n;
				if (16'(data_byte) > sl_n) act = A_FAULT;
				else if (data_byte == 8'd0) act = A_FIN_OBJ;
				else begin bl_n = 16'(data_byte); vs_n = '0; ph_n = PH_COV; end
			end
			PH_COV: begin
				has = 1'b1; tag = smp_pkg::TAG_COV; val = 64'(data_byte); elem = ei_n;
				bytn = vs_n[15:0]; vs_n = vs_n + 64'd1;
				if (bl_n != 16'd0) bl_n = bl_n - 16'd1;
				if (bl_n == 16'd0) act = A_FIN_OBJ;
			end
			PH_AXIS: begin
				has = 1'b1; tag = smp_pkg::TAG_AXIS; val = 64'(data_byte); elem = ei_n;
				act = A_NEED; need_ph = PH_CVAL; need_n = 4'd2;
			end
			PH_PAY, PH_TASK: begin
				has = 1'b1; val = 64'(data_byte);
				tag = (phase_q == PH_PAY) ? smp_pkg::TAG_PAY : smp_pkg::TAG_TASK;
				bytn = vs_n[15:0]; vs_n = vs_n + 64'd1;
				if (sl_n == 16'd0) act = A_NEXT_SEC;
			end
			PH_SKIP: if (sl_n == 16'd0) act = A_NEXT_SEC;
			PH_SKIPF: if (sl_n == 16'd0) ph_n = PH_STOP;
			PH_DONE, PH_STOP: ;
			default: begin
				// big-endian number accumulate
				case (phase_q)
					PH_EXP: width = 4'd4;
					PH_CONF: width = 4'd1;
					PH_WLAT, PH_WLON, PH_WEL, PH_WSP,
					PH_OLAT, PH_OLON, PH_OEL, PH_OVL: width = 4'd8;
					default: width = 4'd2;
				endcase
				vs_n = {vs_n[55:0], data_byte};
				fb_n = fb_n + 4'd1;
				if (fb_n >= width) begin
					case (phase_q)
						PH_HOR: begin
							has = 1'b1; tag = smp_pkg::TAG_HOR; val = vs_n;
							if (vs_n > smp_pkg::MAX_HORIZON) lf_n[smp_pkg::LB_HOR] = 1'b1;
							act = A_NEXT_HDR;
						end
						PH_CONF: begin
							has = 1'b1; tag = smp_pkg::TAG_CONF; val = vs_n;
							if (vs_n > smp_pkg::MAX_CONF) lf_n[smp_pkg::LB_CONF] = 1'b1;
							act = A_NEXT_HDR;
						end
						PH_EXP: begin
							has = 1'b1; tag = smp_pkg::TAG_EXP; val = vs_n; act = A_NEXT_HDR;
						end
						PH_PLEN: begin
							sl_n = vs_n[15:0];
							if (vs_n < 64'd3) act = A_FAULT; else ph_n = PH_FALL;
						end
						PH_OLEN: begin
							sl_n = vs_n[15:0]; act = A_NEED; need_ph = PH_OCNT; need_n = 4'd2;
						end
						PH_CLEN: begin
							sl_n = vs_n[15:0]; act = A_NEED; need_ph = PH_CCNT; need_n = 4'd2;
						end
						PH_BLEN, PH_TLEN: begin
							sl_n = vs_n[15:0];
							if (vs_n != 64'd0)
								ph_n = (phase_q == PH_BLEN) ? PH_PAY : PH_TASK;
							else act = A_NEXT_SEC;
							vs_n = '0;
						end
						PH_WCNT: begin
							has = 1'b1; tag = smp_pkg::TAG_WCNT; val = vs_n;
							if (vs_n == 64'd0 || vs_n > smp_pkg::MAX_WAYPOINTS)
								lf_n[smp_pkg::LB_WPT] = 1'b1;
							el_n = vs_n[15:0]; ei_n = '0; act = A_NEXT_WP;
						end
						PH_WLAT: begin
							has = 1'b1; tag = smp_pkg::TAG_WLAT; val = vs_n; elem = ei_n;
							act = A_NEED; need_ph = PH_WLON; need_n = 4'd8;
						end
						PH_WLON: begin
							has = 1'b1; tag = smp_pkg::TAG_WLON; val = vs_n; elem = ei_n;
							act = A_NEED; need_ph = PH_WELF; need_n = 4'd1;
						end
						PH_WEL: begin
							has = 1'b1; tag = smp_pkg::TAG_WEL; val = vs_n; elem = ei_n;
							act = A_NEED; need_ph = PH_WSPF; need_n = 4'd1;
						end
						PH_WSP: begin
							has = 1'b1; tag = smp_pkg::TAG_WSP; val = vs_n; elem = ei_n;
							mag = {1'b0, vs_n[62:0]};
							// negative: sign set, not zero, not NaN
							if (vs_n[63] && mag != 64'd0 && mag <= smp_pkg::DBL_INF_MAG &&
								!lim_q[smp_pkg::LB_SPD] && !lim_q[smp_pkg::LB_DWELL])
								lf_n[smp_pkg::LB_SPD] = 1'b1;
							act = A_NEED; need_ph = PH_WDWF; need_n = 4'd1;
						end
						PH_WDW: begin
							has = 1'b1; tag = smp_pkg::TAG_WDW; val = vs_n; elem = ei_n;
							if (vs_n > smp_pkg::MAX_DWELL &&
								!lim_q[smp_pkg::LB_SPD] && !lim_q[smp_pkg::LB_DWELL])
								lf_n[smp_pkg::LB_DWELL] = 1'b1;
							act = A_FIN_WP;
						end
						PH_OCNT: begin
							has = 1'b1; tag = smp_pkg::TAG_OCNT; val = vs_n;
							if (vs_n > smp_pkg::MAX_OBJECTS) lf_n[smp_pkg::LB_OBJ] = 1'b1;
							el_n = vs_n[15:0]; ei_n = '0; act = A_NEXT_OBJ;
						end
						PH_OLAT: begin
							has = 1'b1; tag = smp_pkg::TAG_OLAT; val = vs_n; elem = ei_n;
							act = A_NEED; need_ph = PH_OLON; need_n = 4'd8;
						end
						PH_OLON: begin
							has = 1'b1; tag = smp_pkg::TAG_OLON; val = vs_n; elem = ei_n;
							act = A_NEED; need_ph = PH_OELF; need_n = 4'd1;
						end
						PH_OEL: begin
							has = 1'b1; tag = smp_pkg::TAG_OEL; val = vs_n; elem = ei_n;
							act = A_NEED; need_ph = PH_OVLF; need_n = 4'd1;
						end
						PH_OVL: begin
							has = 1'b1; tag = smp_pkg::TAG_OVL; val = vs_n; elem = ei_n;
							act = A_NEED; need_ph = PH_COVL; need_n = 4'd1;
						end
						PH_CCNT: begin
							has = 1'b1; tag = smp_pkg::TAG_CCNT; val = vs_n;
							if (vs_n == 64'd0 || vs_n > smp_pkg::MAX_COMMANDS)
								lf_n[smp_pkg::LB_CMD] = 1'b1;
							el_n = vs_n[15:0]; ei_n = '0; act = A_NEXT_CMD;
						end
						PH_CVAL: begin
							has = 1'b1; tag = smp_pkg::TAG_CVAL; elem = ei_n;
							val = {48'd0, vs_n[15] ^ 1'b1, vs_n[14:0]};
							if (vs_n < smp_pkg::CMD_OFFSET - smp_pkg::CMD_SPAN ||
								vs_n > smp_pkg::CMD_OFFSET + smp_pkg::CMD_SPAN)
								lf_n[smp_pkg::LB_VAL] = 1'b1;
							act = A_FIN_CMD;
						end
						default: ph_n = PH_STOP;
					endcase
				end
			end
		endcase

		// element completion
		if (act == A_FIN_WP || act == A_FIN_OBJ || act == A_FIN_CMD) begin
			ei_n = ei_n + 16'd1;
			if (el_n != 16'd0) el_n = el_n - 16'd1;
			act = (act == A_FIN_WP) ? A_NEXT_WP : (act == A_FIN_OBJ) ? A_NEXT_OBJ : A_NEXT_CMD;
		end
		if (act == A_NEXT_WP) begin
			if (el_n == 16'd0) act = A_END_SEC;
			else begin act = A_NEED; need_ph = PH_WLAT; need_n = 4'd8; end
		end else if (act == A_NEXT_CMD) begin
			if (el_n == 16'd0) act = A_END_SEC;
			else begin act = A_NEED; need_ph = PH_AXIS; need_n = 4'd1; end
		end else if (act == A_NEXT_OBJ) begin
			if (el_n == 16'd0) act = A_END_SEC;
			else if (sl_n < OID_LEN) act = A_FAULT;
			else begin act = A_NONE; ph_n = PH_OID; bl_n = OID_LEN; vs_n = '0; end
		end
		if (act == A_NEXT_HDR) begin
			act = A_NONE; fb_n = '0; vs_n = '0;
			if (pf_n[0]) begin pf_n[0] = 1'b0; ph_n = PH_HOR; end
			else if (pf_n[1]) begin pf_n[1] = 1'b0; ph_n = PH_CONF; end
			else if (pf_n[2]) begin pf_n[2] = 1'b0; ph_n = PH_EXP; end
			else act = A_NEXT_SEC;
		end
		if (act == A_END_SEC) begin
			if (sl_n != 16'd0) begin act = A_NONE; ph_n = PH_SKIP; end
			else act = A_NEXT_SEC;
		end
		if (act == A_NEXT_SEC) begin
			act = A_NONE; fb_n = '0; vs_n = '0;
			if (pf_n[3]) begin pf_n[3] = 1'b0; ph_n = PH_PLEN; end
			else if (pf_n[4]) begin pf_n[4] = 1'b0; ph_n = PH_OLEN; end
			else if (pf_n[5]) begin pf_n[5] = 1'b0; ph_n = PH_CLEN; end
			else if (pf_n[6]) begin pf_n[6] = 1'b0; ph_n = PH_BLEN; end
			else if (pf_n[7]) begin pf_n[7] = 1'b0; ph_n = PH_TLEN; end
			else ph_n = PH_DONE;
		end
		if (act == A_NEED) begin
			if (sl_n < 16'(need_n)) act = A_FAULT;
			else begin act = A_NONE; ph_n = need_ph; fb_n = '0; vs_n = '0; end
		end
		if (act == A_FAULT) begin
			fc_n = smp_pkg::ST_SEC_TRUNC;
			ph_n = (sl_n != 16'd0) ? PH_SKIPF : PH_STOP;
		end

		// end of message status
		if (hc_n < SHORT_LEN) code = smp_pkg::ST_SHORT;
		else if (ph_n == PH_STOP) code = fc_n;
		else if (ph_n != PH_DONE) code = smp_pkg::ST_TRUNC;
		else begin
			code = smp_pkg::ST_OK;
			for (int i = smp_pkg::LIM_BITS - 1; i >= 0; i--)
				if (lf_n[i]) code = smp_pkg::ST_LIM_BASE + 4'(i);
		end

		fr = '{kind: 1'b0, tag: tag, value: val, elem: elem, bytn: bytn,
			status: smp_pkg::ST_OK, run_end: !final_byte};
		sr = '{kind: 1'b1, tag: '0, value: '0, elem: '0, bytn: '0,
			status: code, run_end: 1'b1};
		push_c.count  = 2'(has) + 2'(final_byte);
		push_c.first  = has ? fr : sr;
		push_c.second = sr;
	end

	assign push = accept ? push_c : '{count: 2'd0, first: push_c.first, second: push_c.second};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SID; pflags_q <= '0; hcount_q <= '0; sec_left_q <= '0;
			elem_left_q <= '0; elem_idx_q <= '0; blob_left_q <= '0; fbytes_q <= '0;
			vshift_q <= '0; fault_q <= '0; lim_q <= '0;
		end else if (accept) begin
			if (final_byte) begin
				phase_q <= PH_SID; pflags_q <= '0; hcount_q <= '0; sec_left_q <= '0;
				elem_left_q <= '0; elem_idx_q <= '0; blob_left_q <= '0; fbytes_q <= '0;
				vshift_q <= '0; fault_q <= '0; lim_q <= '0;
			end else begin
				phase_q <= ph_n; pflags_q <= pf_n; hcount_q <= hc_n; sec_left_q <= sl_n;
				elem_left_q <= el_n; elem_idx_q <= ei_n; blob_left_q <= bl_n;
				fbytes_q <= fb_n; vshift_q <= vs_n; fault_q <= fc_n; lim_q <= lf_n;
			end
		end
	end

endmodule

### hdl/smp_result_fifo.sv
// ---------------------------------------------------------------------------
// smp_result_fifo
// Four-entry queue of results: takes up to two, gives one per cycle on pop.
// ---------------------------------------------------------------------------
module smp_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  smp_pkg::push_t    push,
	input  logic              pop,
	output logic              room,
	output logic              avail,
	output smp_pkg::result_t  head
);

	smp_pkg::result_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       do_pop;

	assign avail  = cnt_q != 3'd0;
	assign room   = cnt_q <= 3'd2;
	assign head   = mem_q[rd_q];
	assign do_pop = pop && avail;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_q] <= push.first;
		if (push.count == 2'd2) mem_q[wr_q + 2'd1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.count;
			rd_q  <= rd_q + 2'(do_pop);
			cnt_q <= cnt_q + 3'(push.count) - 3'(do_pop);
		end
	end

endmodule

### hdl/smp_checker.sv
// ---------------------------------------------------------------------------
// smp_checker
// Port-level checks on the result channel.
// ---------------------------------------------------------------------------
module smp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        result_kind,
	input logic [4:0]  field_tag,
	input logic [63:0] field_value,
	input logic [15:0] element_number,
	input logic [15:0] byte_number,
	input logic [3:0]  status_code,
	input logic        run_end
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result dropped while stalled");

	a_value_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(field_value) && $stable(status_code))
		else $error("stalled result changed");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind |-> field_tag == 5'd0 && field_value == 64'd0 &&
			element_number == 16'd0 && byte_number == 16'd0)
		else $error("status result carries field data");

	a_field_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result_kind |-> status_code == 4'd0)
		else $error("field result carries status");

	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind |-> run_end)
		else $error("status result not last of run");

endmodule

bind service_message_parser_unit smp_checker u_smp_checker (
	.clk(clk), .arst_n(arst_n), .valid(out_ch.valid), .ready(out_ch.ready),
	.result_kind(out_ch.result_kind), .field_tag(out_ch.field_tag),
	.field_value(out_ch.field_value), .element_number(out_ch.element_number),
	.byte_number(out_ch.byte_number), .status_code(out_ch.status_code),
	.run_end(out_ch.run_end)
);
